/* sv/swdv_pkg.sv */
`timescale 1ns / 1ps

package swdv_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int DATA_W    = 32;

    localparam logic [DATA_W-1:0] NEG_ONE = {DATA_W{1'b1}};

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_PEEK   = 2'd2,
        OP_DELETE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SEARCH,
        S_SHIFT,
        S_RESP
    } state_t;

    // One finished result handed from the sequencer to the output register
    typedef struct packed {
        logic [DATA_W-1:0] value;
        status_t           status;
    } res_t;

endpackage

/* sv/stack_with_delete_by_value.sv */
`timescale 1ns / 1ps

// Channel   Direction  tdata (low bit up)              tuser (low bit up)
// s_*       in         [31:0] operand_value (signed)   [1:0] op
// m_*       out        [31:0] result_value (signed)    [1:0] status
//
// Steps: push, or any operation that fails at once, goes from accept through
//   S_EXEC to S_RESP; pop and peek add an S_READ step; delete adds an S_SEARCH
//   step per entry compared and an S_SHIFT step per entry moved. The single read
//   port of the entry memory means the search and the gap close visit one entry per cycle.
// Reset: aresetn low at a clock edge empties the stack; memory keeps junk.
// Stalls: s_tready is high only while no item is in work. A finished result
//   waits in the output register, so the next item is taken while m_tready is low.
module stack_with_delete_by_value #(
    parameter int DEPTH = swdv_pkg::DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic signed [swdv_pkg::DATA_W-1:0] s_tdata,   // [31:0] operand_value
    input  logic [1:0]                         s_tuser,   // [1:0] op
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic signed [swdv_pkg::DATA_W-1:0] m_tdata,   // [31:0] result_value
    output logic [1:0]                         m_tuser    // [1:0] status
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    logic                        wr_en;
    logic [ADDR_W-1:0]           wr_addr;
    logic [swdv_pkg::DATA_W-1:0] wr_data;
    logic                        rd_en;
    logic [ADDR_W-1:0]           rd_addr;
    logic [swdv_pkg::DATA_W-1:0] rd_data;

    logic                        out_free;
    logic                        res_valid;
    swdv_pkg::res_t              res;

    logic                        m_tvalid_reg, m_tvalid_next;
    logic [swdv_pkg::DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [1:0]                  m_tuser_reg, m_tuser_next;

    // Entry store: entry 0 is the bottom of the stack
    swdv_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Sequencer: holds the count, walks the memory for delete
    swdv_seq #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .CNT_W  (CNT_W)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (swdv_pkg::op_t'(s_tuser)),
        .in_operand (s_tdata),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res        (res),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    // The output register can take a new result when empty or being drained
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (res_valid) begin
            // load the finished item
            m_tvalid_next = 1'b1;
            m_tdata_next  = res.value;
            m_tuser_next  = res.status;
        end else if (m_tready) begin
            // drop the item once taken
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* sv/swdv_ram.sv */
`timescale 1ns / 1ps

module swdv_ram #(
    parameter int DEPTH  = swdv_pkg::DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [swdv_pkg::DATA_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [swdv_pkg::DATA_W-1:0] rd_data
);

    logic [swdv_pkg::DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* sv/swdv_seq.sv */
`timescale 1ns / 1ps

module swdv_seq #(
    parameter int DEPTH  = swdv_pkg::DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int CNT_W  = $clog2(DEPTH + 1)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  swdv_pkg::op_t               in_op,
    input  logic [swdv_pkg::DATA_W-1:0] in_operand,
    input  logic                        out_free,
    output logic                        res_valid,
    output swdv_pkg::res_t              res,
    output logic                        wr_en,
    output logic [ADDR_W-1:0]           wr_addr,
    output logic [swdv_pkg::DATA_W-1:0] wr_data,
    output logic                        rd_en,
    output logic [ADDR_W-1:0]           rd_addr,
    input  logic [swdv_pkg::DATA_W-1:0] rd_data
);

    swdv_pkg::state_t              state_reg, state_next;
    swdv_pkg::op_t                 op_reg, op_next;
    logic [swdv_pkg::DATA_W-1:0]   val_reg, val_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [ADDR_W-1:0]             ptr_reg, ptr_next;
    swdv_pkg::res_t                res_reg, res_next;

    logic [CNT_W-1:0]  cnt_m1;
    logic [ADDR_W-1:0] top_idx;
    logic [ADDR_W-1:0] ptr_inc;
    logic [ADDR_W-1:0] ptr_inc2;
    logic [ADDR_W-1:0] ptr_dec;
    logic              full;
    logic              empty;
    logic              match;

    assign cnt_m1   = count_reg - 1'b1;
    assign top_idx  = cnt_m1[ADDR_W-1:0];
    assign ptr_inc  = ptr_reg + 1'b1;
    assign ptr_inc2 = ptr_inc + 1'b1;
    assign ptr_dec  = ptr_reg - 1'b1;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    // the one comparator, reused for every entry that the search visits
    assign match    = (rd_data == val_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= swdv_pkg::S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg  <= op_next;
        val_reg <= val_next;
        ptr_reg <= ptr_next;
        res_reg <= res_next;
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        val_next   = val_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        res_next   = res_reg;
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = ptr_reg;
        wr_data    = rd_data;
        rd_en      = 1'b0;
        rd_addr    = ptr_reg;

        unique case (state_reg)
            swdv_pkg::S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op_next    = in_op;
                    val_next   = in_operand;
                    state_next = swdv_pkg::S_EXEC;
                end
            end
            swdv_pkg::S_EXEC: begin
                unique case (op_reg)
                    swdv_pkg::OP_PUSH: begin
                        state_next = swdv_pkg::S_RESP;
                        if (full) begin
                            res_next = '{value: swdv_pkg::NEG_ONE, status: swdv_pkg::ST_FULL};
                        end else begin
                            wr_en      = 1'b1;
                            wr_addr    = count_reg[ADDR_W-1:0];
                            wr_data    = val_reg;
                            count_next = count_reg + 1'b1;
                            res_next   = '{value: swdv_pkg::NEG_ONE, status: swdv_pkg::ST_OK};
                        end
                    end
                    swdv_pkg::OP_POP, swdv_pkg::OP_PEEK: begin
                        if (empty) begin
                            res_next   = '{value: swdv_pkg::NEG_ONE, status: swdv_pkg::ST_EMPTY};
                            state_next = swdv_pkg::S_RESP;
                        end else begin
                            rd_en      = 1'b1;
                            rd_addr    = top_idx;
                            state_next = swdv_pkg::S_READ;
                        end
                    end
                    swdv_pkg::OP_DELETE: begin
                        if (empty) begin
                            res_next   = '{value: swdv_pkg::NEG_ONE, status: swdv_pkg::ST_EMPTY};
                            state_next = swdv_pkg::S_RESP;
                        end else begin
                            rd_en      = 1'b1;
                            rd_addr    = top_idx;
                            ptr_next   = top_idx;
                            state_next = swdv_pkg::S_SEARCH;
                        end
                    end
                    default: begin
                        state_next = swdv_pkg::S_IDLE;
                    end
                endcase
            end
            swdv_pkg::S_READ: begin
                res_next = '{value: rd_data, status: swdv_pkg::ST_OK};
                if (op_reg == swdv_pkg::OP_POP) begin
                    count_next = cnt_m1;
                end
                state_next = swdv_pkg::S_RESP;
            end
            swdv_pkg::S_SEARCH: begin
                // rd_data holds the entry at ptr_reg
                if (match) begin
                    if (ptr_reg == top_idx) begin
                        count_next = cnt_m1;
                        res_next   = '{value: swdv_pkg::NEG_ONE, status: swdv_pkg::ST_OK};
                        state_next = swdv_pkg::S_RESP;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = ptr_inc;
                        state_next = swdv_pkg::S_SHIFT;
                    end
                end else if (ptr_reg == '0) begin
                    res_next   = '{value: swdv_pkg::NEG_ONE, status: swdv_pkg::ST_NOTFOUND};
                    state_next = swdv_pkg::S_RESP;
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = ptr_dec;
                    ptr_next = ptr_dec;
                end
            end
            swdv_pkg::S_SHIFT: begin
                // rd_data holds the entry above ptr_reg: move it down one place
                wr_en    = 1'b1;
                wr_addr  = ptr_reg;
                wr_data  = rd_data;
                ptr_next = ptr_inc;
                if (ptr_inc < top_idx) begin
                    rd_en   = 1'b1;
                    rd_addr = ptr_inc2;
                end else begin
                    count_next = cnt_m1;
                    res_next   = '{value: swdv_pkg::NEG_ONE, status: swdv_pkg::ST_OK};
                    state_next = swdv_pkg::S_RESP;
                end
            end
            swdv_pkg::S_RESP: begin
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = swdv_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = swdv_pkg::S_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_res_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> out_free)
        else $error("result handed over while output register is busy");

    a_full_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == swdv_pkg::S_EXEC && op_reg == swdv_pkg::OP_PUSH && full)
        |=> $stable(count_reg))
        else $error("push to full stack changed the count");

    a_shift_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == swdv_pkg::S_SHIFT) |-> (ptr_reg < top_idx))
        else $error("gap close ran past the top entry");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == swdv_pkg::S_IDLE || state_reg == swdv_pkg::S_RESP) |-> !wr_en)
        else $error("memory written outside an operation");

endmodule

/* tb/stack_with_delete_by_value_checker.sv */
`timescale 1ns / 1ps

module stack_with_delete_by_value_checker #(
    parameter int DEPTH = swdv_pkg::DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [swdv_pkg::DATA_W-1:0]   s_tdata,    // [31:0] operand_value
    input  logic [1:0]                    s_tuser,    // [1:0] op
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [swdv_pkg::DATA_W-1:0]   m_tdata,    // [31:0] result_value
    input  logic [1:0]                    m_tuser,    // [1:0] status
    output int                            err_count,
    output int                            pending
);

    logic [swdv_pkg::DATA_W-1:0] words [DEPTH];
    int                          held;
    int                          fails;
    swdv_pkg::res_t              awaiting [$];

    // Apply one request to the shadow stack and return its result
    function automatic swdv_pkg::res_t stack_apply(swdv_pkg::op_t op,
                                                   logic [swdv_pkg::DATA_W-1:0] operand);
        swdv_pkg::res_t r;
        int             hit;
        r.value  = swdv_pkg::NEG_ONE;
        r.status = swdv_pkg::ST_OK;
        hit      = -1;
        unique case (op)
            swdv_pkg::OP_PUSH: begin
                if (held >= DEPTH) begin
                    r.status = swdv_pkg::ST_FULL;
                end else begin
                    words[held] = operand;
                    held++;
                end
            end
            swdv_pkg::OP_POP: begin
                if (held == 0) begin
                    r.status = swdv_pkg::ST_EMPTY;
                end else begin
                    held--;
                    r.value = words[held];
                end
            end
            swdv_pkg::OP_PEEK: begin
                if (held == 0) begin
                    r.status = swdv_pkg::ST_EMPTY;
                end else begin
                    r.value = words[held-1];
                end
            end
            default: begin
                if (held == 0) begin
                    r.status = swdv_pkg::ST_EMPTY;
                end else begin
                    for (int i = held - 1; i >= 0; i--) begin
                        if (hit < 0 && words[i] == operand) begin
                            hit = i;
                        end
                    end
                    if (hit < 0) begin
                        r.status = swdv_pkg::ST_NOTFOUND;
                    end else begin
                        for (int j = hit; j < held - 1; j++) begin
                            words[j] = words[j+1];
                        end
                        held--;
                    end
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        swdv_pkg::res_t want;
        if (!aresetn) begin
            held = 0;
            fails = 0;
            awaiting.delete();
            err_count <= 0;
            pending   <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (awaiting.size() == 0) begin
                    $error("unexpected item: result_value %0d status %0d",
                           $signed(m_tdata), m_tuser);
                    fails++;
                end else begin
                    want = awaiting.pop_front();
                    if (m_tdata !== want.value) begin
                        $error("result_value: expected %0d, got %0d",
                               $signed(want.value), $signed(m_tdata));
                        fails++;
                    end
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        fails++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                awaiting.push_back(stack_apply(swdv_pkg::op_t'(s_tuser), s_tdata));
            end
            err_count <= fails;
            pending   <= awaiting.size();
        end
    end

endmodule

/* tb/stack_with_delete_by_value_tb.sv */
`timescale 1ns / 1ps

module stack_with_delete_by_value_tb;

    localparam int STACK_DEPTH  = swdv_pkg::DEPTH_DEF;
    localparam int RANDOM_ITEMS = 900;
    // Watchdog limit: room for the worst delete plus both sides' stalls, many times over
    localparam int IDLE_LIMIT   = 4000;

    // Flavors of random traffic: each one pushes the stack toward a different region
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN,
        MIX_DELETE
    } mix_t;

    logic                               aclk;
    logic                               aresetn;
    logic                               s_tvalid;
    logic                               s_tready;
    logic signed [swdv_pkg::DATA_W-1:0] s_tdata;     // [31:0] operand_value
    logic [1:0]                         s_tuser;     // [1:0] op
    logic                               m_tvalid;
    logic                               m_tready;
    logic signed [swdv_pkg::DATA_W-1:0] m_tdata;     // [31:0] result_value
    logic [1:0]                         m_tuser;     // [1:0] status

    int err_count;
    int pending;
    int idle_cycles;
    bit tx_burst;
    bit rx_calm;
    int rx_hold;
    int rx_stretch;

    stack_with_delete_by_value #(
        .DEPTH(STACK_DEPTH)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    stack_with_delete_by_value_checker #(
        .DEPTH(STACK_DEPTH)
    ) chk (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .err_count(err_count),
        .pending  (pending)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // Result side: after each accepted item hold tready low for a random
    // number of cycles; switch now and then to a calm stretch with no stalls.
    always @(posedge aclk) begin
        int stall;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            rx_hold    <= 0;
            rx_calm    <= 1'b0;
            rx_stretch <= 30;
        end else if (m_tready) begin
            if (m_tvalid) begin
                stall = rx_calm ? 0 : $urandom_range(0, 8);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    rx_hold  <= stall - 1;
                end
                if (rx_stretch == 0) begin
                    rx_calm    <= ~rx_calm;
                    rx_stretch <= $urandom_range(10, 60);
                end else begin
                    rx_stretch <= rx_stretch - 1;
                end
            end
        end else if (rx_hold == 0) begin
            m_tready <= 1'b1;
        end else begin
            rx_hold <= rx_hold - 1;
        end
    end

    // Watchdog: end the run if neither channel moves an item for too long
    always @(posedge aclk) begin
        if (!aresetn) begin
            idle_cycles <= 0;
        end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Present one request and hold it until the block takes it. Valid stays
    // high across back-to-back items so it is never dropped and raised in one step.
    task automatic send_item(input swdv_pkg::op_t op,
                             input logic [swdv_pkg::DATA_W-1:0] operand);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= operand;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop valid and hold off until every outstanding result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    // Half the values come from a tiny pool so deletes find matches and
    // duplicates pile up; the rest are full-width random words.
    function automatic logic [swdv_pkg::DATA_W-1:0] pick_value();
        if ($urandom_range(0, 1) == 1) begin
            return $urandom_range(0, 7) - 4;
        end
        return $urandom;
    endfunction

    function automatic swdv_pkg::op_t pick_op(mix_t mix);
        int r;
        int w_push;
        int w_pop;
        int w_peek;
        r = $urandom_range(0, 99);
        unique case (mix)
            MIX_FILL:   begin w_push = 80; w_pop = 5;  w_peek = 5;  end
            MIX_DRAIN:  begin w_push = 10; w_pop = 70; w_peek = 10; end
            MIX_DELETE: begin w_push = 40; w_pop = 5;  w_peek = 5;  end
            default:    begin w_push = 25; w_pop = 25; w_peek = 25; end
        endcase
        if (r < w_push) begin
            return swdv_pkg::OP_PUSH;
        end else if (r < w_push + w_pop) begin
            return swdv_pkg::OP_POP;
        end else if (r < w_push + w_pop + w_peek) begin
            return swdv_pkg::OP_PEEK;
        end
        return swdv_pkg::OP_DELETE;
    endfunction

    initial begin
        mix_t mix;
        int   sent;
        int   seg_len;
        bit   first_seg;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = swdv_pkg::OP_PUSH;
        tx_burst = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty stack: every read-type request must report empty
        send_item(swdv_pkg::OP_POP, 32'h0000_0000);
        send_item(swdv_pkg::OP_PEEK, 32'hFFFF_FFFF);
        send_item(swdv_pkg::OP_DELETE, 32'h0000_0000);
        // Field extremes and alternating bit patterns
        send_item(swdv_pkg::OP_PUSH, 32'h7FFF_FFFF);
        send_item(swdv_pkg::OP_PUSH, 32'h8000_0000);
        send_item(swdv_pkg::OP_PUSH, 32'hFFFF_FFFF);
        send_item(swdv_pkg::OP_PUSH, 32'h0000_0000);
        send_item(swdv_pkg::OP_PUSH, 32'hAAAA_AAAA);
        send_item(swdv_pkg::OP_PUSH, 32'h5555_5555);
        // Duplicates: delete removes only the copy nearest the top
        send_item(swdv_pkg::OP_PUSH, 32'd5);
        send_item(swdv_pkg::OP_PUSH, 32'd7);
        send_item(swdv_pkg::OP_PUSH, 32'd5);
        send_item(swdv_pkg::OP_PEEK, 32'd0);
        send_item(swdv_pkg::OP_DELETE, 32'd5);
        send_item(swdv_pkg::OP_POP, 32'd0);
        // Miss, then a delete deep in the stack that closes a gap
        send_item(swdv_pkg::OP_DELETE, 32'd123);
        send_item(swdv_pkg::OP_DELETE, 32'h8000_0000);
        send_item(swdv_pkg::OP_POP, 32'd0);
        send_item(swdv_pkg::OP_DELETE, 32'h5555_5555);
        send_item(swdv_pkg::OP_POP, 32'd0);
        send_item(swdv_pkg::OP_POP, 32'd0);
        // A stored -1 comes back with an ok status
        send_item(swdv_pkg::OP_POP, 32'd0);
        send_item(swdv_pkg::OP_PEEK, 32'd0);
        send_item(swdv_pkg::OP_POP, 32'd0);
        send_item(swdv_pkg::OP_POP, 32'd0);
        wait_drained();

        // Random segments, each with its own traffic mix and idling style;
        // long fill segments can run the stack into full.
        sent      = 0;
        first_seg = 1'b1;
        while (sent < RANDOM_ITEMS) begin
            mix      = mix_t'($urandom_range(0, 3));
            seg_len  = $urandom_range(40, 110);
            tx_burst = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < seg_len && sent < RANDOM_ITEMS; k++) begin
                send_item(pick_op(mix), pick_value());
                sent++;
            end
            if (first_seg || $urandom_range(0, 2) == 0) begin
                wait_drained();
            end
            first_seg = 1'b0;
        end

        // Drain, then give the block time to show any stray result
        wait_drained();
        repeat (2 * STACK_DEPTH + 8) @(posedge aclk);
        if (err_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/swdv_pkg.sv
sv/swdv_ram.sv
sv/swdv_seq.sv
sv/stack_with_delete_by_value.sv
tb/stack_with_delete_by_value_checker.sv
tb/stack_with_delete_by_value_tb.sv
